>>> design/itp_pkg.sv
// Package for the infix-to-postfix converter: stack sizing, character codes,
// result kinds, precedence functions and the stack control struct.
// No dependencies.
`default_nettype none
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_END   = 2'd1,
    KIND_OVER  = 2'd2,
    KIND_CLOSE = 2'd3
  } kind_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } stack_ctl_t;

  function automatic logic is_op(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_MUL) || (c == CH_DIV) ||
           (c == CH_POW) || (c == CH_LPAR) || (c == CH_RPAR);
  endfunction

  function automatic logic [2:0] prec_out(input logic [7:0] c);
    logic [2:0] p;
    p = 3'd0;
    if ((c == CH_PLUS) || (c == CH_MINUS)) p = 3'd1;
    else if ((c == CH_MUL) || (c == CH_DIV)) p = 3'd3;
    else if (c == CH_POW) p = 3'd6;
    else if (c == CH_LPAR) p = 3'd7;
    return p;
  endfunction

  function automatic logic [2:0] prec_in(input logic [7:0] c);
    logic [2:0] p;
    p = 3'd0;
    if ((c == CH_PLUS) || (c == CH_MINUS)) p = 3'd2;
    else if ((c == CH_MUL) || (c == CH_DIV)) p = 3'd4;
    else if (c == CH_POW) p = 3'd5;
    return p;
  endfunction

endpackage
`default_nettype wire

>>> design/infix_to_postfix_converter.sv
// Infix-to-postfix converter top level: sequencer around one precedence
// compare, the operator stack and a pending/output result pair. Uses itp_pkg and itp_stack.
// Each stack pop is a memory read then a compare (S_READ, S_CMP), repeated per
// popped entry for an operator; a flush reads and pops (S_FREAD, S_FPOP) per
// stacked entry. One item at a time; in_stall is high while busy.
// Reset: synchronous, empties the stack and drops any pending result.
`default_nettype none
module infix_to_postfix_converter (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_char,
  input  wire logic          expr_last,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_char,
  output itp_pkg::kind_t     kind,
  output logic               run_last,
  output logic               expr_end
);
  import itp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CMP, S_FREAD, S_FPOP, S_END
  } state_t;

  state_t           state, state_next;
  logic [7:0]       cur;
  logic             last_q;
  logic             pend_valid;
  logic [7:0]       pend_char;
  kind_t            pend_kind;
  stack_ctl_t       ctl;
  logic [CNT_W-1:0] count;
  logic [7:0]       top;
  logic             out_free, slot_ok;
  logic             want, gen, fin;
  logic [7:0]       gen_char;
  kind_t            gen_kind;
  logic [2:0]       po, pi;
  stack_ctl_t       ctl_want;
  state_t           want_state;

  itp_stack u_stack (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .count (count),
    .top   (top)
  );

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign slot_ok  = !pend_valid || out_free;
  assign po       = prec_out(cur);
  assign pi       = prec_in(top);

  always_comb begin
    want       = 1'b0;
    gen_char   = 8'd0;
    gen_kind   = KIND_CHAR;
    ctl_want   = '0;
    want_state = state;
    fin        = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!is_op(in_char)) begin
            want       = 1'b1;
            gen_char   = in_char;
            want_state = expr_last ? S_FREAD : S_END;
          end else begin
            want_state = S_READ;
          end
        end
      end
      S_READ: want_state = S_CMP;
      S_CMP: begin
        want_state = last_q ? S_FREAD : S_END;
        if (count == '0) begin
          if (cur == CH_RPAR) begin
            want     = 1'b1;
            gen_kind = KIND_CLOSE;
          end else begin
            ctl_want.push  = 1'b1;
            ctl_want.wdata = cur;
          end
        end else if (po > pi) begin
          if (count < CNT_W'(STACK_DEPTH)) begin
            ctl_want.push  = 1'b1;
            ctl_want.wdata = cur;
          end else begin
            want     = 1'b1;
            gen_kind = KIND_OVER;
          end
        end else if (po == pi) begin
          ctl_want.pop = 1'b1;
        end else begin
          want         = 1'b1;
          gen_char     = top;
          ctl_want.pop = 1'b1;
          want_state   = S_READ;
        end
      end
      S_FREAD: want_state = (count == '0) ? S_END : S_FPOP;
      S_FPOP: begin
        want         = 1'b1;
        gen_char     = top;
        ctl_want.pop = 1'b1;
        want_state   = S_FREAD;
      end
      S_END: begin
        if (!(pend_valid || last_q)) begin
          want_state = S_IDLE;
        end else if (out_free) begin
          fin        = 1'b1;
          want_state = S_IDLE;
        end
      end
      default: want_state = S_IDLE;
    endcase
    if (want && !slot_ok) begin
      gen        = 1'b0;
      ctl        = '0;
      state_next = state;
    end else begin
      gen        = want;
      ctl        = ctl_want;
      state_next = want_state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (gen) begin
        if (pend_valid) begin
          out_valid <= 1'b1;
          out_char  <= pend_char;
          kind      <= pend_kind;
          run_last  <= 1'b0;
          expr_end  <= 1'b0;
        end else if (out_valid && !out_stall) begin
          out_valid <= 1'b0;
        end
        pend_valid <= 1'b1;
        pend_char  <= gen_char;
        pend_kind  <= gen_kind;
      end else if (fin) begin
        out_valid  <= 1'b1;
        out_char   <= pend_valid ? pend_char : 8'd0;
        kind       <= pend_valid ? pend_kind : KIND_END;
        run_last   <= 1'b1;
        expr_end   <= last_q;
        pend_valid <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (state == S_IDLE && in_valid) begin
      cur    <= in_char;
      last_q <= expr_last;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid)
    else $error("pending result left while idle");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && expr_end |-> run_last)
    else $error("expression end without run end");

  a_marker_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_END |-> expr_end)
    else $error("end marker without expression end");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> count < CNT_W'(STACK_DEPTH))
    else $error("push into full stack");
`endif

endmodule
`default_nettype wire

>>> design/itp_stack.sv
// Operator stack: memory with push/pop, a fill count and a registered top read.
// The top value is valid in the cycle after the count settles. Uses itp_pkg.
`default_nettype none
module itp_stack (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire itp_pkg::stack_ctl_t     ctl,
  output logic [itp_pkg::CNT_W-1:0]    count,
  output logic [7:0]                   top
);
  import itp_pkg::*;

  logic [7:0]       op_stack [STACK_DEPTH];
  logic [CNT_W-1:0] top_pos;

  assign top_pos = count - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      op_stack[count[IDX_W-1:0]] <= ctl.wdata;
    end
    top <= op_stack[top_pos[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.push) begin
      count <= count + CNT_W'(1);
    end else if (ctl.pop) begin
      count <= count - CNT_W'(1);
    end
  end

endmodule
`default_nettype wire
